### rtl/core/cia_pkg.sv
// Package: shared constants, codes and controller/datapath structs of the checked integer ALU.
`default_nettype none

package cia_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_MOD = 3'd4;
    localparam logic [2:0] FN_POW = 3'd5;
    localparam logic [2:0] FN_MIN = 3'd6;
    localparam logic [2:0] FN_MAX = 3'd7;

    localparam logic [1:0] ERR_DIV_ZERO = 2'd0;
    localparam logic [1:0] ERR_BAD_NUM  = 2'd1;
    localparam logic [1:0] ERR_BAD_ARGS = 2'd2;

    localparam logic [1:0] KIND_QUICK = 2'd0;
    localparam logic [1:0] KIND_MUL   = 2'd1;
    localparam logic [1:0] KIND_DIV   = 2'd2;
    localparam logic [1:0] KIND_POW   = 2'd3;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic pow_next;
        logic finish;
    } cia_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       pow_more;
    } cia_status_t;

endpackage

`default_nettype wire

### rtl/core/cia_in_if.sv
// Interface: input word channel of the checked integer ALU.
`default_nettype none

interface cia_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic        unary;
    logic [63:0] a_value;
    logic        a_is_error;
    logic [1:0]  a_error_code;
    logic [63:0] b_value;
    logic        b_is_error;
    logic [1:0]  b_error_code;

    modport source (output valid, func, unary, a_value, a_is_error, a_error_code,
                    b_value, b_is_error, b_error_code, input ready);
    modport sink   (input valid, func, unary, a_value, a_is_error, a_error_code,
                    b_value, b_is_error, b_error_code, output ready);
endinterface

`default_nettype wire

### rtl/core/cia_out_if.sv
// Interface: result word channel of the checked integer ALU.
`default_nettype none

interface cia_out_if;
    logic        valid;
    logic        ready;
    logic        is_error;
    logic [1:0]  error_code;
    logic [63:0] value;

    modport source (output valid, is_error, error_code, value, input ready);
    modport sink   (input valid, is_error, error_code, value, output ready);
endinterface

`default_nettype wire

### rtl/core/checked_integer_alu.sv
// Top level: checked integer ALU joining the controller and the datapath.
//
//  channel   direction  payload
//  in_ch     sink       func, unary, a_value, a_is_error, a_error_code,
//                       b_value, b_is_error, b_error_code
//  out_ch    source     is_error, error_code, value
//
// One word is worked on at a time. Words settled directly go from load through dispatch
// to the result register; multiply and divide run the 64-step shift-add and restoring units.
// Power runs one multiply per exponent step, at most 63 steps. Reset clears the controller
// only. A word waiting on out_ch does not block the next input; the next result waits in
// its final state until the register is free.
`default_nettype none

module checked_integer_alu
(
    input wire logic  clk,
    input wire logic  rst_n,
    cia_in_if.sink    in_ch,
    cia_out_if.source out_ch
);
    import cia_pkg::*;

    cia_cmd_t    cmd;
    cia_status_t status;

    cia_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    cia_dp u_dp
    (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .func         (in_ch.func),
        .unary        (in_ch.unary),
        .a_value      (in_ch.a_value),
        .a_is_error   (in_ch.a_is_error),
        .a_error_code (in_ch.a_error_code),
        .b_value      (in_ch.b_value),
        .b_is_error   (in_ch.b_is_error),
        .b_error_code (in_ch.b_error_code),
        .is_error     (out_ch.is_error),
        .error_code   (out_ch.error_code),
        .value        (out_ch.value)
    );

endmodule

`default_nettype wire

### rtl/core/cia_dp.sv
// Datapath: operand classification, shift-add multiplier, restoring divider and result register.
`default_nettype none

module cia_dp
(
    input  wire logic                 clk,
    input  wire cia_pkg::cia_cmd_t    cmd,
    output cia_pkg::cia_status_t      status,
    input  wire logic [2:0]           func,
    input  wire logic                 unary,
    input  wire logic [63:0]          a_value,
    input  wire logic                 a_is_error,
    input  wire logic [1:0]           a_error_code,
    input  wire logic [63:0]          b_value,
    input  wire logic                 b_is_error,
    input  wire logic [1:0]           b_error_code,
    output logic                      is_error,
    output logic [1:0]                error_code,
    output logic [63:0]               value
);
    import cia_pkg::*;

    localparam logic [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] W_ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    logic [DATA_WIDTH-1:0] a, b, ma, mb;
    logic                  q_err;
    logic [1:0]            q_code;
    logic [DATA_WIDTH-1:0] q_val;
    logic [1:0]            q_kind;

    logic [2:0]            func_reg;
    logic [1:0]            kind_reg;
    logic                  sgn_reg;
    logic                  res_err_reg;
    logic [1:0]            res_code_reg;
    logic [DATA_WIDTH-1:0] res_val_reg;
    logic [DATA_WIDTH-1:0] mcand_reg;
    logic [DATA_WIDTH-1:0] shift_reg;
    logic [DATA_WIDTH-1:0] p_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] exp_reg;
    logic                  ovf_reg;
    logic                  out_err_reg;
    logic [1:0]            out_code_reg;
    logic [DATA_WIDTH-1:0] out_val_reg;

    logic [DATA_WIDTH+1:0] prod_sum;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   rem_diff;
    logic                  rem_ge;
    logic [DATA_WIDTH-1:0] div_base;
    logic                  fin_err;
    logic [1:0]            fin_code;
    logic [DATA_WIDTH-1:0] fin_val;

    assign a  = a_value[DATA_WIDTH-1:0];
    assign b  = b_value[DATA_WIDTH-1:0];
    assign ma = a[DATA_WIDTH-1] ? (~a + W_ONE) : a;
    assign mb = b[DATA_WIDTH-1] ? (~b + W_ONE) : b;

    always_comb
    begin
        q_err  = 1'b0;
        q_code = ERR_DIV_ZERO;
        q_val  = '0;
        q_kind = KIND_QUICK;
        priority if (a_is_error)
        begin
            q_err  = 1'b1;
            q_code = a_error_code;
        end
        else if (unary)
        begin
            unique case (func)
                FN_ADD, FN_MIN, FN_MAX: q_val = a;
                FN_SUB:
                begin
                    if (a == W_MIN)
                    begin
                        q_err  = 1'b1;
                        q_code = ERR_BAD_NUM;
                    end
                    else
                    begin
                        q_val = ~a + W_ONE;
                    end
                end
                default:
                begin
                    q_err  = 1'b1;
                    q_code = ERR_BAD_ARGS;
                end
            endcase
        end
        else if (b_is_error)
        begin
            q_err  = 1'b1;
            q_code = b_error_code;
        end
        else
        begin
            unique case (func)
                FN_ADD: q_val = a + b;
                FN_SUB: q_val = a - b;
                FN_MUL: q_kind = KIND_MUL;
                FN_DIV, FN_MOD:
                begin
                    if (b == '0)
                    begin
                        q_err  = 1'b1;
                        q_code = ERR_DIV_ZERO;
                    end
                    else if (a == W_MIN && b == '1)
                    begin
                        if (func == FN_DIV)
                        begin
                            q_err  = 1'b1;
                            q_code = ERR_BAD_NUM;
                        end
                    end
                    else
                    begin
                        q_kind = KIND_DIV;
                    end
                end
                FN_POW:
                begin
                    if (b[DATA_WIDTH-1])
                    begin
                        q_err  = 1'b1;
                        q_code = ERR_BAD_NUM;
                    end
                    else if (b == '0)
                    begin
                        q_val = W_ONE;
                    end
                    else if (ma == '0)
                    begin
                        q_val = '0;
                    end
                    else if (ma == W_ONE)
                    begin
                        q_val = (a[DATA_WIDTH-1] && b[0]) ? '1 : W_ONE;
                    end
                    else
                    begin
                        q_kind = KIND_POW;
                    end
                end
                FN_MIN: q_val = ($signed(a) < $signed(b)) ? a : b;
                default: q_val = ($signed(b) < $signed(a)) ? a : b;
            endcase
        end
    end

    assign prod_sum = {1'b0, p_reg, 1'b0}
                    + (shift_reg[DATA_WIDTH-1] ? {2'b00, mcand_reg} : '0);
    assign rem_sh   = {rem_reg, shift_reg[DATA_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, mcand_reg};
    assign rem_ge   = rem_sh >= {1'b0, mcand_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= func;
            kind_reg     <= q_kind;
            res_err_reg  <= q_err;
            res_code_reg <= q_code;
            res_val_reg  <= q_val;
            p_reg        <= '0;
            rem_reg      <= '0;
            ovf_reg      <= 1'b0;
            exp_reg      <= b;
            if (func == FN_DIV || func == FN_MOD)
            begin
                mcand_reg <= mb;
                shift_reg <= ma;
            end
            else
            begin
                mcand_reg <= ma;
                shift_reg <= (func == FN_POW) ? W_ONE : mb;
            end
            unique case (func)
                FN_MOD:  sgn_reg <= a[DATA_WIDTH-1];
                FN_POW:  sgn_reg <= a[DATA_WIDTH-1] & b[0];
                default: sgn_reg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            endcase
        end
        else if (cmd.mul_step)
        begin
            p_reg     <= prod_sum[DATA_WIDTH-1:0];
            ovf_reg   <= ovf_reg | (prod_sum > {2'b00, W_MAX});
            shift_reg <= {shift_reg[DATA_WIDTH-2:0], 1'b0};
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= rem_ge ? rem_diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
            shift_reg <= {shift_reg[DATA_WIDTH-2:0], rem_ge};
        end
        else if (cmd.pow_next)
        begin
            shift_reg <= p_reg;
            p_reg     <= '0;
            exp_reg   <= exp_reg - W_ONE;
        end
    end

    assign div_base = (func_reg == FN_MOD) ? rem_reg : shift_reg;

    always_comb
    begin
        fin_err  = 1'b0;
        fin_code = ERR_DIV_ZERO;
        fin_val  = '0;
        unique case (kind_reg)
            KIND_QUICK:
            begin
                fin_err  = res_err_reg;
                fin_code = res_code_reg;
                fin_val  = res_val_reg;
            end
            KIND_DIV:
            begin
                fin_val = sgn_reg ? (~div_base + W_ONE) : div_base;
            end
            default:
            begin
                if (ovf_reg)
                begin
                    fin_err  = 1'b1;
                    fin_code = ERR_BAD_NUM;
                end
                else
                begin
                    fin_val = sgn_reg ? (~p_reg + W_ONE) : p_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_err_reg  <= fin_err;
            out_code_reg <= fin_code;
            out_val_reg  <= fin_val;
        end
    end

    assign status.kind     = kind_reg;
    assign status.pow_more = !ovf_reg && (exp_reg != W_ONE);

    assign is_error   = out_err_reg;
    assign error_code = out_code_reg;
    assign value      = 64'($signed(out_val_reg));

endmodule

`default_nettype wire

### rtl/core/cia_ctrl.sv
// Controller: state machine sequencing load, serial steps, power rounds and result hand-off.
`default_nettype none

module cia_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cia_pkg::cia_cmd_t          cmd,
    input  wire cia_pkg::cia_status_t  status
);
    import cia_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POW  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DATA_WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cnt_next = CNT_TOP;
                unique case (status.kind)
                    KIND_QUICK: state_next = S_FIN;
                    KIND_DIV:   state_next = S_DIV;
                    default:    state_next = S_MUL;
                endcase
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - CNT_ONE;
                if (cnt_reg == '0)
                begin
                    state_next = (status.kind == KIND_POW) ? S_POW : S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_ONE;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_POW:
            begin
                if (status.pow_more)
                begin
                    cmd.pow_next = 1'b1;
                    cnt_next     = CNT_TOP;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/cia_checker.sv
// Checker: port-level assertions of the checked integer ALU and its bind.
`default_nettype none

module cia_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        is_error,
    input wire logic [1:0]  error_code,
    input wire logic [63:0] value
);
    import cia_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn before it was taken");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> value == 64'd0)
        else $error("error word carries a non-zero value");

    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_error |-> error_code == ERR_DIV_ZERO)
        else $error("numeric word carries an error code");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is still being worked on");

endmodule

bind checked_integer_alu cia_checker u_cia_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .is_error   (out_ch.is_error),
    .error_code (out_ch.error_code),
    .value      (out_ch.value)
);

`default_nettype wire
